### hdl/hcl_pkg.sv
`default_nettype none

package hcl_pkg;

  // Field widths of the line walk
  localparam int unsigned CoordW = 5;   // signed hex component
  localparam int unsigned DeltaW = 6;   // signed end minus start
  localparam int unsigned DistW  = 5;   // unsigned distance and step index
  localparam int unsigned ProdW  = 10;  // signed start times distance
  localparam int unsigned RemW   = 8;   // signed remainder of the running division
  localparam int unsigned ErrW   = 7;   // doubled rounding error
  localparam int unsigned SumW   = 7;   // signed component before saturation

  localparam int unsigned QueueDepth        = 2;
  localparam int          CoordLimitDefault = 15;
  localparam int          CoordMax          = (1 << (CoordW - 1)) - 1;

  typedef struct packed {
    logic [2:0][CoordW-1:0] start;
    logic [2:0][DeltaW-1:0] delta;
    logic [2:0][ProdW-1:0]  prod;
    logic [DistW-1:0]       span;
  } line_entry_t;

  typedef struct packed {
    logic        valid;
    line_entry_t entry;
  } line_xfer_t;

  typedef enum logic [1:0] {
    WALK_IDLE = 2'b01,
    WALK_RUN  = 2'b10
  } walk_state_e;

  // Clamp the configured limit to the range the field widths can carry.
  function automatic logic [CoordW-1:0] eff_limit(input int lim);
    int l;
    l = lim;
    if (l > CoordMax) l = CoordMax;
    if (l < 1) l = 1;
    return CoordW'(l);
  endfunction

  // Saturate a widened component to [-lim, lim].
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] x,
                                                         input logic [CoordW-1:0] lim);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = $signed({{(SumW - CoordW){1'b0}}, lim});
    lo = -hi;
    if (x > hi) return hi[CoordW-1:0];
    if (x < lo) return lo[CoordW-1:0];
    return x[CoordW-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/hcl_if.sv
`default_nettype none

interface hcl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hcl_pkg::CoordW-1:0]   start_q;
  logic signed [hcl_pkg::CoordW-1:0]   start_r;
  logic signed [hcl_pkg::CoordW-1:0]   start_s;
  logic signed [hcl_pkg::CoordW-1:0]   end_q;
  logic signed [hcl_pkg::CoordW-1:0]   end_r;
  logic signed [hcl_pkg::CoordW-1:0]   end_s;

  modport source (output valid, start_q, start_r, start_s, end_q, end_r, end_s,
                  input ready);
  modport sink (input valid, start_q, start_r, start_s, end_q, end_r, end_s,
                output ready);
endinterface

interface hcl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hcl_pkg::CoordW-1:0]   point_q;
  logic signed [hcl_pkg::CoordW-1:0]   point_r;
  logic signed [hcl_pkg::CoordW-1:0]   point_s;
  logic        [hcl_pkg::DistW-1:0]    step_number;
  logic                                last_point;

  modport source (output valid, point_q, point_r, point_s, step_number, last_point,
                  input ready);
  modport sink (input valid, point_q, point_r, point_s, step_number, last_point,
                output ready);
endinterface

`default_nettype wire

### hdl/hex_cube_line_walk_core.sv
// The first point of a line passes through the queue, the walker load and the output register.
// Each line takes a load step, then one point per cycle while the output is ready; the back
//   walker, with its per-component division steps, sets this and takes no new line until the last point.
// The two-entry queue takes new lines while the walker is busy.
// Reset: asynchronous, active low; clears the queue, the walker state and output valid.
`default_nettype none

module hex_cube_line_walk_core #(
  parameter int COORD_LIMIT = hcl_pkg::CoordLimitDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcl_in_if.sink     in_i,
  hcl_out_if.source  out_o
);
  import hcl_pkg::*;

  localparam int Lim = int'(eff_limit(COORD_LIMIT));

  line_xfer_t push_s;
  line_xfer_t pop_s;
  logic       push_ready_s;
  logic       take_s;

  // Saturate the inputs, find the distance and the scaled starting values.
  hcl_front #(
    .COORD_LIMIT (COORD_LIMIT)
  ) u_front (
    .in_i         (in_i),
    .push_ready_i (push_ready_s),
    .push_o       (push_s)
  );

  // Hold classified lines until the walker is free.
  hcl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_s),
    .push_ready_o (push_ready_s),
    .pop_o        (pop_s),
    .take_i       (take_s)
  );

  // Walk the line, round each point and rebuild the worst component.
  hcl_back #(
    .COORD_LIMIT (COORD_LIMIT)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pop_i  (pop_s),
    .take_o (take_s),
    .out_o  (out_o)
  );

  // An accepted line lands in the queue by the next cycle.
  a_push_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> pop_s.valid)
    else $error("accepted line missing from queue");

  // After a transfer that is not the last point, the next point is ready at once.
  a_walk_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_point |=>
      out_o.valid && (out_o.step_number == $past(out_o.step_number) + 5'd1))
    else $error("line walk broke its step sequence");

  // The walker only takes a line when the queue has one.
  a_take_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_s |-> pop_s.valid)
    else $error("walker took from an empty queue");

  // Every shown point lies inside the coordinate limit.
  a_point_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.point_q <= Lim) && (out_o.point_q >= -Lim) &&
                    (out_o.point_r <= Lim) && (out_o.point_r >= -Lim) &&
                    (out_o.point_s <= Lim) && (out_o.point_s >= -Lim))
    else $error("point outside coordinate limit");

endmodule

`default_nettype wire

### hdl/hcl_front.sv
`default_nettype none

module hcl_front #(
  parameter int COORD_LIMIT = hcl_pkg::CoordLimitDefault
) (
  hcl_in_if.sink              in_i,
  input  logic                push_ready_i,
  output hcl_pkg::line_xfer_t push_o
);
  import hcl_pkg::*;

  localparam logic [CoordW-1:0] Limit = eff_limit(COORD_LIMIT);

  logic signed [CoordW-1:0] raw_a [3];
  logic signed [CoordW-1:0] raw_b [3];
  logic signed [CoordW-1:0] sat_a [3];
  logic signed [CoordW-1:0] sat_b [3];
  logic signed [DeltaW-1:0] delta [3];
  logic        [DistW-1:0]  mag   [3];
  logic        [DistW-1:0]  span;
  logic signed [ProdW-1:0]  prod_full [3];

  assign raw_a[0] = in_i.start_q;
  assign raw_a[1] = in_i.start_r;
  assign raw_a[2] = in_i.start_s;
  assign raw_b[0] = in_i.end_q;
  assign raw_b[1] = in_i.end_r;
  assign raw_b[2] = in_i.end_s;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat_a[c] = sat_coord($signed({{(SumW - CoordW){raw_a[c][CoordW-1]}}, raw_a[c]}), Limit);
      sat_b[c] = sat_coord($signed({{(SumW - CoordW){raw_b[c][CoordW-1]}}, raw_b[c]}), Limit);
      delta[c] = $signed({sat_b[c][CoordW-1], sat_b[c]}) -
                 $signed({sat_a[c][CoordW-1], sat_a[c]});
      mag[c]   = delta[c][DeltaW-1] ? DistW'(-delta[c]) : DistW'(delta[c]);
    end
  end

  // Distance is the largest component step.
  always_comb begin
    span = mag[0];
    if (mag[1] > span) span = mag[1];
    if (mag[2] > span) span = mag[2];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_full[c] = sat_a[c] * $signed({1'b0, span});
    end
  end

  always_comb begin
    push_o.valid = in_i.valid;
    push_o.entry.span = span;
    for (int c = 0; c < 3; c++) begin
      push_o.entry.start[c] = sat_a[c];
      push_o.entry.delta[c] = delta[c];
      push_o.entry.prod[c]  = prod_full[c];
    end
  end

  assign in_i.ready = push_ready_i;

endmodule

`default_nettype wire

### hdl/hcl_queue.sv
`default_nettype none

module hcl_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcl_pkg::line_xfer_t push_i,
  output logic                push_ready_o,
  output hcl_pkg::line_xfer_t pop_o,
  input  logic                take_i
);
  import hcl_pkg::*;

  // Depth is a power of two so the pointers wrap on their own.
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  line_entry_t         slot_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = take_i && (count_q != '0);

  assign pop_o.valid = (count_q != '0);
  assign pop_o.entry = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    if (!do_push && do_pop) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_i.entry;
  end

endmodule

`default_nettype wire

### hdl/hcl_back.sv
`default_nettype none

module hcl_back #(
  parameter int COORD_LIMIT = hcl_pkg::CoordLimitDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcl_pkg::line_xfer_t pop_i,
  output logic                take_o,
  hcl_out_if.source           out_o
);
  import hcl_pkg::*;

  localparam logic [CoordW-1:0] Limit = eff_limit(COORD_LIMIT);

  walk_state_e state_q, state_d;

  // Running value v = a*d + delta*i, plus two floor divisions by 2d:
  // p = floor((2v+d)/2d) serves v >= 0, m = floor((2v+d-1)/2d) serves v < 0.
  logic signed [ProdW-1:0]  v_q  [3];
  logic signed [DeltaW-1:0] p_q  [3];
  logic signed [DeltaW-1:0] m_q  [3];
  logic signed [RemW-1:0]   rp_q [3];
  logic signed [RemW-1:0]   rm_q [3];
  logic signed [DeltaW-1:0] dl_q [3];
  logic        [DistW-1:0]  dist_q;
  logic        [DistW-1:0]  step_q;

  logic signed [CoordW-1:0] pt_q [3];
  logic        [DistW-1:0]  step_out_q;
  logic                     last_out_q;
  logic                     out_valid_q;

  logic signed [RemW-1:0]   dist_r, two_d, dl2 [3];
  logic signed [RemW-1:0]   rp_sum [3], rm_sum [3], diff [3];
  logic signed [RemW-1:0]   rp_nx [3], rm_nx [3];
  logic signed [DeltaW-1:0] p_nx [3], m_nx [3];
  logic signed [DeltaW-1:0] n [3];
  logic        [ErrW-1:0]   err [3];
  logic signed [CoordW-1:0] pt [3];
  logic signed [SumW-1:0]   rebuild [3];
  logic                     emit, last_now;

  assign dist_r   = $signed({{(RemW - DistW){1'b0}}, dist_q});
  assign two_d    = dist_r <<< 1;
  assign last_now = (step_q == dist_q);
  assign emit     = (state_q == WALK_RUN) && (!out_valid_q || out_o.ready);
  assign take_o   = (state_q == WALK_IDLE) && pop_i.valid;

  // Pick the rounded value and its doubled error.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (v_q[c][ProdW-1]) begin
        n[c]    = m_q[c];
        diff[c] = rm_q[c] - dist_r + RemW'(1);
      end else begin
        n[c]    = p_q[c];
        diff[c] = rp_q[c] - dist_r;
      end
      err[c] = diff[c][RemW-1] ? ErrW'(-diff[c]) : ErrW'(diff[c]);
    end
  end

  // Rebuild the component with the largest error; a tie with s falls to s, a q-r tie falls to r.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pt[c] = n[c][CoordW-1:0];
    end
    rebuild[0] = -$signed({n[1][DeltaW-1], n[1]}) - $signed({n[2][DeltaW-1], n[2]});
    rebuild[1] = -$signed({n[0][DeltaW-1], n[0]}) - $signed({n[2][DeltaW-1], n[2]});
    rebuild[2] = -$signed({n[0][DeltaW-1], n[0]}) - $signed({n[1][DeltaW-1], n[1]});
    priority if (err[0] > err[1] && err[0] > err[2]) begin
      pt[0] = sat_coord(rebuild[0], Limit);
    end else if (err[1] > err[2]) begin
      pt[1] = sat_coord(rebuild[1], Limit);
    end else begin
      pt[2] = sat_coord(rebuild[2], Limit);
    end
  end

  // Advance each division by one step; one correction keeps the remainder in [0, 2d).
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dl2[c]    = $signed({{(RemW - DeltaW - 1){dl_q[c][DeltaW-1]}}, dl_q[c], 1'b0});
      rp_sum[c] = rp_q[c] + dl2[c];
      rm_sum[c] = rm_q[c] + dl2[c];
      p_nx[c]   = p_q[c];
      m_nx[c]   = m_q[c];
      rp_nx[c]  = rp_sum[c];
      rm_nx[c]  = rm_sum[c];
      priority if (rp_sum[c] >= two_d) begin
        p_nx[c]  = p_q[c] + DeltaW'(1);
        rp_nx[c] = rp_sum[c] - two_d;
      end else if (rp_sum[c] < 0) begin
        p_nx[c]  = p_q[c] - DeltaW'(1);
        rp_nx[c] = rp_sum[c] + two_d;
      end
      priority if (rm_sum[c] >= two_d) begin
        m_nx[c]  = m_q[c] + DeltaW'(1);
        rm_nx[c] = rm_sum[c] - two_d;
      end else if (rm_sum[c] < 0) begin
        m_nx[c]  = m_q[c] - DeltaW'(1);
        rm_nx[c] = rm_sum[c] + two_d;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      WALK_IDLE: if (pop_i.valid) state_d = WALK_RUN;
      WALK_RUN:  if (emit && last_now) state_d = WALK_IDLE;
      default:   state_d = WALK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WALK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      dist_q <= pop_i.entry.span;
      step_q <= '0;
      for (int c = 0; c < 3; c++) begin
        v_q[c]  <= $signed(pop_i.entry.prod[c]);
        dl_q[c] <= $signed(pop_i.entry.delta[c]);
        p_q[c]  <= $signed({pop_i.entry.start[c][CoordW-1], pop_i.entry.start[c]});
        m_q[c]  <= $signed({pop_i.entry.start[c][CoordW-1], pop_i.entry.start[c]});
        rp_q[c] <= $signed({{(RemW - DistW){1'b0}}, pop_i.entry.span});
        rm_q[c] <= $signed({{(RemW - DistW){1'b0}}, pop_i.entry.span}) - RemW'(1);
      end
    end else if (emit) begin
      step_q <= step_q + DistW'(1);
      for (int c = 0; c < 3; c++) begin
        v_q[c]  <= v_q[c] + $signed({{(ProdW - DeltaW){dl_q[c][DeltaW-1]}}, dl_q[c]});
        p_q[c]  <= p_nx[c];
        m_q[c]  <= m_nx[c];
        rp_q[c] <= rp_nx[c];
        rm_q[c] <= rm_nx[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      for (int c = 0; c < 3; c++) begin
        pt_q[c] <= pt[c];
      end
      step_out_q <= step_q;
      last_out_q <= last_now;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.point_q     = pt_q[0];
  assign out_o.point_r     = pt_q[1];
  assign out_o.point_s     = pt_q[2];
  assign out_o.step_number = step_out_q;
  assign out_o.last_point  = last_out_q;

endmodule

`default_nettype wire
